### hdl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared constants and types for the servo status packet parser: sizes of
// the parameter store, the packet descriptor passed from the byte parser to
// the result emitter, and the parameter store write port.
// ----------------------------------------------------------------------------
package ssp_pkg;

    // parameter bytes kept per packet
    localparam int MAX_PARAMS  = 16;
    localparam int IDX_W       = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int CNT_W       = $clog2(MAX_PARAMS + 1);
    // two banks of parameters, bank select on the top address bit
    localparam int ADDR_W      = IDX_W + 1;
    localparam int MEM_DEPTH   = 2 ** ADDR_W;
    // descriptor queue, one entry per parameter bank
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] HEADER_BYTE  = 8'hFF;
    localparam logic [7:0] LEN_OVERHEAD = 8'd2;

    // parameter store write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

    // one parsed packet waiting to be emitted
    typedef struct packed {
        logic [7:0]       id;
        logic [7:0]       err;
        logic [CNT_W-1:0] stored;
        logic             ok;
        logic             len_err;
        logic             bank;
    } t_desc;

endpackage

### hdl/ssp_front.sv
// ----------------------------------------------------------------------------
// ssp_front
// Byte parser: walks the status packet framing, keeps the running sum,
// writes parameter bytes into the current bank and pushes one descriptor
// per packet at the checksum byte.
// ----------------------------------------------------------------------------
module ssp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    output ssp_pkg::t_mem_wr o_wr,
    output logic             o_push,
    output ssp_pkg::t_desc   o_desc
);

    typedef enum logic [2:0] {
        S_HEAD1,
        S_HEAD2,
        S_ID,
        S_LEN,
        S_ERR,
        S_PARAMS,
        S_CHECK
    } t_phase;

    t_phase     r_phase;
    logic [7:0] r_id;
    logic [7:0] r_len;
    logic [7:0] r_err;
    logic [7:0] r_count;
    logic [7:0] r_sum;
    logic       r_bank;

    logic [7:0] expected;
    logic       last_param;
    logic       too_many;

    // parameters announced by the length byte
    always_comb begin
        expected   = (r_len < ssp_pkg::LEN_OVERHEAD) ? 8'd0 : r_len - ssp_pkg::LEN_OVERHEAD;
        last_param = ({1'b0, r_count} + 9'd1) >= {1'b0, expected};
        too_many   = expected > 8'(ssp_pkg::MAX_PARAMS);
    end

    // parameter store write, extra bytes beyond capacity dropped
    always_comb begin
        o_wr.en   = i_valid && (r_phase == S_PARAMS) && (r_count < 8'(ssp_pkg::MAX_PARAMS));
        o_wr.addr = {r_bank, r_count[ssp_pkg::IDX_W-1:0]};
        o_wr.data = i_byte;
    end

    // descriptor for the emitter at the checksum byte
    always_comb begin
        o_push         = i_valid && (r_phase == S_CHECK);
        o_desc.id      = r_id;
        o_desc.err     = r_err;
        o_desc.stored  = too_many ? ssp_pkg::CNT_W'(ssp_pkg::MAX_PARAMS)
                                  : ssp_pkg::CNT_W'(expected);
        o_desc.ok      = (i_byte == ~r_sum);
        o_desc.len_err = (r_len < ssp_pkg::LEN_OVERHEAD) || too_many;
        o_desc.bank    = r_bank;
    end

    // framing state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= S_HEAD1;
            r_id    <= '0;
            r_len   <= '0;
            r_err   <= '0;
            r_count <= '0;
            r_sum   <= '0;
            r_bank  <= 1'b0;
        end else if (i_valid) begin
            unique case (r_phase)
                S_HEAD1: begin
                    if (i_byte == ssp_pkg::HEADER_BYTE) r_phase <= S_HEAD2;
                end
                S_HEAD2: begin
                    r_phase <= (i_byte == ssp_pkg::HEADER_BYTE) ? S_ID : S_HEAD1;
                end
                S_ID: begin
                    r_id    <= i_byte;
                    r_sum   <= i_byte;
                    r_phase <= S_LEN;
                end
                S_LEN: begin
                    r_len   <= i_byte;
                    r_sum   <= r_sum + i_byte;
                    r_count <= '0;
                    r_phase <= S_ERR;
                end
                S_ERR: begin
                    r_err   <= i_byte;
                    r_sum   <= r_sum + i_byte;
                    r_phase <= (expected == 8'd0) ? S_CHECK : S_PARAMS;
                end
                S_PARAMS: begin
                    r_sum   <= r_sum + i_byte;
                    r_count <= r_count + 8'd1;
                    if (last_param) r_phase <= S_CHECK;
                end
                S_CHECK: begin
                    r_bank  <= ~r_bank;
                    r_phase <= S_HEAD1;
                end
                default: r_phase <= S_HEAD1;
            endcase
        end
    end

endmodule

### hdl/ssp_queue.sv
// ----------------------------------------------------------------------------
// ssp_queue
// Short descriptor queue between the parser and the emitter. The head entry
// stays until the emitter has read its last parameter, so the queue fill also
// tells which parameter banks are still in use.
// ----------------------------------------------------------------------------
module ssp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ssp_pkg::t_desc i_desc,
    input  logic           i_pop,
    output ssp_pkg::t_desc o_head,
    output logic           o_valid,
    output logic           o_full
);

    ssp_pkg::t_desc                r_entry [ssp_pkg::QUEUE_DEPTH];
    logic [ssp_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [ssp_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [ssp_pkg::QCNT_W-1:0]    r_fill;

    assign o_head  = r_entry[r_rd_ptr];
    assign o_valid = (r_fill != '0);
    assign o_full  = (r_fill == ssp_pkg::QCNT_W'(ssp_pkg::QUEUE_DEPTH));

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_entry[r_wr_ptr] <= i_desc;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            unique case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

### hdl/ssp_back.sv
// ----------------------------------------------------------------------------
// ssp_back
// Result emitter: holds the two-bank parameter store and walks the head
// descriptor one parameter per beat into the output register.
// ----------------------------------------------------------------------------
module ssp_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ssp_pkg::t_mem_wr           i_wr,
    input  ssp_pkg::t_desc             i_head,
    input  logic                       i_head_valid,
    output logic                       o_head_pop,
    input  logic                       i_pop,
    output logic                       o_valid,
    output logic [7:0]                 o_packet_id,
    output logic [7:0]                 o_error_flags,
    output logic [4:0]                 o_param_count,
    output logic [3:0]                 o_param_index,
    output logic [7:0]                 o_param_byte,
    output logic                       o_checksum_ok,
    output logic                       o_length_error,
    output logic                       o_last
);

    logic [7:0]                r_mem [ssp_pkg::MEM_DEPTH];
    logic [ssp_pkg::IDX_W-1:0] r_k;
    logic                      r_out_valid;
    logic [7:0]                r_packet_id;
    logic [7:0]                r_error_flags;
    logic [4:0]                r_param_count;
    logic [3:0]                r_param_index;
    logic [7:0]                r_param_byte;
    logic                      r_checksum_ok;
    logic                      r_length_error;
    logic                      r_last;

    logic                      load;
    logic [ssp_pkg::CNT_W-1:0] run_len;
    logic                      is_last;

    // beat control
    always_comb begin
        load       = i_head_valid && (!r_out_valid || i_pop);
        run_len    = (i_head.stored == '0) ? ssp_pkg::CNT_W'(1) : i_head.stored;
        is_last    = (ssp_pkg::CNT_W'(r_k) + ssp_pkg::CNT_W'(1)) == run_len;
        o_head_pop = load && is_last;
    end

    // parameter store write
    always_ff @(posedge i_clk) begin
        if (i_wr.en) r_mem[i_wr.addr] <= i_wr.data;
    end

    // parameter read and result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_packet_id    <= i_head.id;
            r_error_flags  <= i_head.err;
            r_param_count  <= 5'(i_head.stored);
            r_param_index  <= 4'(r_k);
            r_param_byte   <= (i_head.stored == '0) ? 8'd0 : r_mem[{i_head.bank, r_k}];
            r_checksum_ok  <= i_head.ok;
            r_length_error <= i_head.len_err;
            r_last         <= is_last;
        end
    end

    // output valid and parameter index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_k         <= is_last ? '0 : r_k + 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_packet_id    = r_packet_id;
    assign o_error_flags  = r_error_flags;
    assign o_param_count  = r_param_count;
    assign o_param_index  = r_param_index;
    assign o_param_byte   = r_param_byte;
    assign o_checksum_ok  = r_checksum_ok;
    assign o_length_error = r_length_error;
    assign o_last         = r_last;

endmodule

### hdl/servo_status_packet_parser.sv
// ----------------------------------------------------------------------------
// servo_status_packet_parser
// Parses servo status packets from a byte stream and emits one result beat
// per stored parameter byte.
// ----------------------------------------------------------------------------
// Bytes enter one per cycle through push/full and are framed as 0xFF 0xFF id
// length error params checksum. At the checksum byte the packet is queued,
// and once the output register is free its first result is loaded from the
// queue head into that register, then one beat per cycle while pop is held:
// max(N,1) beats for a packet holding N stored parameters (at most 16).
// Parameters sit in two banks, so up to two parsed packets may wait for
// emission; full rises only while both banks are held, and then every input
// byte stalls until the older packet's last parameter has been read from its
// bank. Lengths below 2 or announcing more parameters than capacity raise
// length_error; parameter bytes past capacity are summed but not kept.
module servo_status_packet_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_packet_id,
    output logic [7:0] o_error_flags,
    output logic [4:0] o_param_count,
    output logic [3:0] o_param_index,
    output logic [7:0] o_param_byte,
    output logic       o_checksum_ok,
    output logic       o_length_error,
    output logic       o_last
);

    ssp_pkg::t_mem_wr wr;
    ssp_pkg::t_desc   desc_in;
    ssp_pkg::t_desc   desc_head;
    logic             desc_push;
    logic             desc_pop;
    logic             desc_valid;
    logic             q_full;
    logic             out_valid;
    logic             in_beat;

    assign full    = q_full;
    assign in_beat = push && !q_full;
    assign empty   = !out_valid;

    // byte parser
    ssp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_beat),
        .i_byte  (i_rx_byte),
        .o_wr    (wr),
        .o_push  (desc_push),
        .o_desc  (desc_in)
    );

    // packet descriptor queue
    ssp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_push),
        .i_desc  (desc_in),
        .i_pop   (desc_pop),
        .o_head  (desc_head),
        .o_valid (desc_valid),
        .o_full  (q_full)
    );

    // result emitter
    ssp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr           (wr),
        .i_head         (desc_head),
        .i_head_valid   (desc_valid),
        .o_head_pop     (desc_pop),
        .i_pop          (pop),
        .o_valid        (out_valid),
        .o_packet_id    (o_packet_id),
        .o_error_flags  (o_error_flags),
        .o_param_count  (o_param_count),
        .o_param_index  (o_param_index),
        .o_param_byte   (o_param_byte),
        .o_checksum_ok  (o_checksum_ok),
        .o_length_error (o_length_error),
        .o_last         (o_last)
    );

endmodule

### hdl/ssp_checker.sv
// ----------------------------------------------------------------------------
// ssp_checker
// Port-level checks on the result stream of the status packet parser.
// ----------------------------------------------------------------------------
module ssp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [4:0] o_param_count,
    input logic [3:0] o_param_index,
    input logic [7:0] o_param_byte,
    input logic       o_last
);

    // result stream is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result present after reset");

    // a waiting beat holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_param_index) && $stable(o_param_byte)))
        else $error("waiting result changed");

    // packet without parameters gives a single zero beat
    a_no_params: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_param_count == 5'd0) |->
            (o_last && o_param_index == 4'd0 && o_param_byte == 8'd0))
        else $error("bad result for packet without parameters");

    // last beat sits at the final stored parameter
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last && o_param_count != 5'd0) |->
            ({1'b0, o_param_index} + 5'd1 == o_param_count))
        else $error("last marker on wrong parameter");

    // beats of one packet come in index order
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(!empty && pop && !o_last) && !empty) |->
            (o_param_index == $past(o_param_index) + 4'd1))
        else $error("parameter index out of order");

endmodule

bind servo_status_packet_parser ssp_checker u_ssp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_param_count (o_param_count),
    .o_param_index (o_param_index),
    .o_param_byte  (o_param_byte),
    .o_last        (o_last)
);
